[src/snt_pkg.sv]
// ----------------------------------------------------------------------------
// Semitone note tracker package
// Field widths, fixed constants and the constant functions that build the
// equal-tempered boundary table in unsigned Q15.7 hertz.
// ----------------------------------------------------------------------------
package snt_pkg;

   localparam int FREQ_W = 22;
   localparam int NOTE_W = 7;
   localparam int OCT_W  = 4;
   localparam int RUN_W  = 16;

   localparam logic [FREQ_W-1:0] Q8_MAX        = {FREQ_W{1'b1}};
   localparam logic [RUN_W-1:0]  RUN_MAX       = {RUN_W{1'b1}};
   localparam logic [NOTE_W-1:0] NONE_NOTE     = 7'd127;
   localparam logic [RUN_W-1:0]  MIN_SEG_RESET = 16'd2;

   localparam int unsigned NOTES_PER_OCTAVE = 12;
   localparam logic [63:0] BASE_C0          = 64'd163516;
   localparam logic [63:0] DIVISOR          = 64'd10000 << 23;
   localparam logic [63:0] DIVISOR_HALF     = DIVISOR / 64'd2;
   localparam logic [63:0] DIVISOR_TWICE    = DIVISOR * 64'd2;

   localparam logic [31:0] SEMITONE_RATIO [12] = '{
      32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
      32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
      32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
   };

   function automatic logic [63:0] wide_pitch(input int unsigned j);
      logic [63:0] v;
      v = BASE_C0 * 64'(SEMITONE_RATIO[j % NOTES_PER_OCTAVE]);
      return v << (j / NOTES_PER_OCTAVE);
   endfunction

   function automatic logic [FREQ_W-1:0] sat_q8(input logic [63:0] v);
      return (v > 64'(Q8_MAX)) ? Q8_MAX : v[FREQ_W-1:0];
   endfunction

   function automatic logic [FREQ_W-1:0] centre_q8(input int unsigned i);
      return sat_q8((wide_pitch(i + 12) + DIVISOR_HALF) / DIVISOR);
   endfunction

   function automatic logic [FREQ_W-1:0] bound_q8(input int unsigned i);
      return sat_q8((wide_pitch(i + 11) + wide_pitch(i + 12) + DIVISOR) / DIVISOR_TWICE);
   endfunction

   // Octave is the note divided by twelve, done as a multiply by 171/2048,
   // which is exact for every seven-bit note.
   function automatic logic [OCT_W-1:0] octave_of(input logic [NOTE_W-1:0] note);
      logic [14:0] prod;
      prod = 15'(note) * 15'd171;
      return prod[14:11];
   endfunction

endpackage

[src/semitone_note_tracker_core.sv]
// ----------------------------------------------------------------------------
// Semitone note tracker core
// Maps each frequency item onto an equal-tempered semitone by a binary search
// over a registered boundary ROM and tracks runs of the same note.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  req_frequency
//   rsp_      out        rsp_valid/rsp_stall  accepted, note_index, octave,
//                                             note_changed, replaced_short,
//                                             run_length
//   csr_      in         csr_wr_en            csr_wr_data
//
// An item passes from acceptance through one probe state per search bit,
// $clog2(active notes) of them with one boundary ROM probe per cycle, then
// a check state and a write state that loads the result; only then does the
// core return to idle and accept the next item. Reset is synchronous and
// clears the search control, the run state and the result valid; the minimum
// length returns to two. A stalled result is held in the output register,
// and a finished search waits for it to leave, which also holds off the next item.
// ----------------------------------------------------------------------------
module semitone_note_tracker_core
   import snt_pkg::*;
#(
   parameter int OCTAVES = 9,
   parameter int NOTES   = 108
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [FREQ_W-1:0] req_frequency,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_accepted,
   output logic [NOTE_W-1:0] rsp_note_index,
   output logic [OCT_W-1:0]  rsp_octave,
   output logic              rsp_note_changed,
   output logic              rsp_replaced_short,
   output logic [RUN_W-1:0]  rsp_run_length,
   input  logic              csr_wr_en,
   input  logic [RUN_W-1:0]  csr_wr_data
);

   localparam int ACTIVE    = (NOTES < OCTAVES * 12) ? NOTES : OCTAVES * 12;
   localparam int NB        = $clog2(ACTIVE);
   localparam int AW        = NB + 1;
   localparam int ROM_DEPTH = 1 << AW;

   localparam logic [FREQ_W-1:0] CENTRE_LO = centre_q8(0);
   localparam logic [FREQ_W-1:0] CENTRE_HI = centre_q8(ACTIVE - 1);
   localparam logic [NB-1:0]     TOP_BIT   = NB'(1) << (NB - 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_PROBE = 2'd1;
   localparam logic [1:0] ST_CHECK = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [FREQ_W-1:0] bound_rom [ROM_DEPTH];

   for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
      if (k <= ACTIVE) begin : g_used
         assign bound_rom[k] = bound_q8(k);
      end else begin : g_pad
         assign bound_rom[k] = Q8_MAX;
      end
   end

   logic [1:0]        state_ff, state_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;
   logic              range_ok_ff, range_ok_in;
   logic [NB-1:0]     n_ff, n_in;
   logic [NB-1:0]     cand_ff, cand_in;
   logic [NB-1:0]     bit_ff, bit_in;
   logic              found_ff, found_in;
   logic [FREQ_W-1:0] rom_q_ff;
   logic [AW-1:0]     rom_addr_in;
   logic [NOTE_W-1:0] cur_note_ff, cur_note_in;
   logic [RUN_W-1:0]  seg_len_ff, seg_len_in;
   logic [RUN_W-1:0]  min_seg_ff, min_seg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_accepted_ff, rsp_accepted_in;
   logic [NOTE_W-1:0] rsp_note_ff, rsp_note_in;
   logic [OCT_W-1:0]  rsp_octave_ff, rsp_octave_in;
   logic              rsp_changed_ff, rsp_changed_in;
   logic              rsp_replaced_ff, rsp_replaced_in;
   logic [RUN_W-1:0]  rsp_run_ff, rsp_run_in;

   logic              out_free;
   logic              take;
   logic [NB-1:0]     n_sel;
   logic [NB-1:0]     bit_nx;
   logic [NB-1:0]     cand_nx;
   logic [NOTE_W-1:0] note_val;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign take     = rom_q_ff < freq_ff;
   assign n_sel    = take ? cand_ff : n_ff;
   assign bit_nx   = bit_ff >> 1;
   assign cand_nx  = n_sel | bit_nx;
   assign note_val = NOTE_W'(n_ff);

   always_comb begin
      state_in        = state_ff;
      freq_in         = freq_ff;
      range_ok_in     = range_ok_ff;
      n_in            = n_ff;
      cand_in         = cand_ff;
      bit_in          = bit_ff;
      found_in        = found_ff;
      rom_addr_in     = '0;
      cur_note_in     = cur_note_ff;
      seg_len_in      = seg_len_ff;
      min_seg_in      = min_seg_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_accepted_in = rsp_accepted_ff;
      rsp_note_in     = rsp_note_ff;
      rsp_octave_in   = rsp_octave_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_replaced_in = rsp_replaced_ff;
      rsp_run_in      = rsp_run_ff;
      if (csr_wr_en) begin
         min_seg_in = csr_wr_data;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               freq_in     = req_frequency;
               range_ok_in = (req_frequency >= CENTRE_LO) && (req_frequency <= CENTRE_HI);
               n_in        = '0;
               cand_in     = TOP_BIT;
               bit_in      = TOP_BIT;
               rom_addr_in = AW'(TOP_BIT);
               state_in    = ST_PROBE;
            end
         end
         ST_PROBE: begin
            n_in = n_sel;
            if (bit_ff[0]) begin
               rom_addr_in = AW'(n_sel) + AW'(1);
               state_in    = ST_CHECK;
            end else begin
               bit_in      = bit_nx;
               cand_in     = cand_nx;
               rom_addr_in = AW'(cand_nx);
            end
         end
         ST_CHECK: begin
            found_in = range_ok_ff && (rom_q_ff != freq_ff);
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_accepted_in = 1'b0;
               rsp_note_in     = '0;
               rsp_octave_in   = '0;
               rsp_changed_in  = 1'b0;
               rsp_replaced_in = 1'b0;
               if (found_ff) begin
                  rsp_accepted_in = 1'b1;
                  rsp_note_in     = note_val;
                  rsp_octave_in   = octave_of(note_val);
                  if (note_val == cur_note_ff) begin
                     if (seg_len_ff != RUN_MAX) begin
                        seg_len_in = seg_len_ff + RUN_W'(1);
                     end
                  end else begin
                     rsp_changed_in  = 1'b1;
                     rsp_replaced_in = seg_len_ff < min_seg_ff;
                     cur_note_in     = note_val;
                     seg_len_in      = RUN_W'(1);
                  end
               end
               rsp_run_in = seg_len_in;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rom_q_ff <= bound_rom[rom_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cur_note_ff  <= NONE_NOTE;
         seg_len_ff   <= '0;
         min_seg_ff   <= MIN_SEG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_note_ff  <= cur_note_in;
         seg_len_ff   <= seg_len_in;
         min_seg_ff   <= min_seg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff         <= freq_in;
      range_ok_ff     <= range_ok_in;
      n_ff            <= n_in;
      cand_ff         <= cand_in;
      bit_ff          <= bit_in;
      found_ff        <= found_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_note_ff     <= rsp_note_in;
      rsp_octave_ff   <= rsp_octave_in;
      rsp_changed_ff  <= rsp_changed_in;
      rsp_replaced_ff <= rsp_replaced_in;
      rsp_run_ff      <= rsp_run_in;
   end

   assign req_stall          = state_ff != ST_IDLE;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_accepted       = rsp_accepted_ff;
   assign rsp_note_index     = rsp_note_ff;
   assign rsp_octave         = rsp_octave_ff;
   assign rsp_note_changed   = rsp_changed_ff;
   assign rsp_replaced_short = rsp_replaced_ff;
   assign rsp_run_length     = rsp_run_ff;

endmodule

[src/snt_checker.sv]
// ----------------------------------------------------------------------------
// Semitone note tracker checker
// Port-level assertions on the result channel, bound to the core.
// ----------------------------------------------------------------------------
module snt_checker
   import snt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_accepted,
   input logic [NOTE_W-1:0] rsp_note_index,
   input logic [OCT_W-1:0]  rsp_octave,
   input logic              rsp_note_changed,
   input logic              rsp_replaced_short,
   input logic [RUN_W-1:0]  rsp_run_length
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_note_index)
         && $stable(rsp_run_length) && $stable(rsp_accepted))
      else $error("Stalled result item changed.");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_accepted |-> rsp_note_index == '0 && rsp_octave == '0
         && !rsp_note_changed && !rsp_replaced_short)
      else $error("Rejected item carries note data.");

   a_replace_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_replaced_short |-> rsp_note_changed)
      else $error("Replacement flagged without a note event.");

   a_new_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_note_changed |-> rsp_accepted && rsp_run_length == RUN_W'(1))
      else $error("New run does not start at length one.");

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_run_length != '0)
      else $error("Accepted item reports an empty run.");

endmodule

bind semitone_note_tracker_core snt_checker u_snt_checker (.*);

[bench/tb_note_checker.sv]
// ----------------------------------------------------------------------------
// Note tracker result checker
// Watches the request, result and register ports of the semitone note
// tracker. Each accepted frequency is mapped onto a note by a private copy
// of the boundary table and run state, and the predicted result is queued.
// Each result taken by the receiver is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module tb_note_checker
   import snt_pkg::*;
#(
   parameter int OCTAVES = 9,
   parameter int NOTES   = 108
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [FREQ_W-1:0] req_frequency,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_accepted,
   input  logic [NOTE_W-1:0] rsp_note_index,
   input  logic [OCT_W-1:0]  rsp_octave,
   input  logic              rsp_note_changed,
   input  logic              rsp_replaced_short,
   input  logic [RUN_W-1:0]  rsp_run_length,
   input  logic              csr_wr_en,
   input  logic [RUN_W-1:0]  csr_wr_data,
   output int                fail_count,
   output int                pending
);

   localparam int ACTIVE = (NOTES < OCTAVES * 12) ? NOTES : OCTAVES * 12;
   localparam logic [63:0] C0_SCALED = 64'd163516;
   localparam logic [63:0] PITCH_DEN = 64'd10000 << 23;
   localparam logic [31:0] STEP_RATIO [12] = '{
      32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
      32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
      32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
   };

   typedef struct packed {
      logic              accepted;
      logic [NOTE_W-1:0] note_index;
      logic [OCT_W-1:0]  octave;
      logic              note_changed;
      logic              replaced_short;
      logic [RUN_W-1:0]  run_length;
   } note_result_type;

   logic [FREQ_W-1:0] centre_tab [ACTIVE];
   logic [FREQ_W-1:0] bound_tab [ACTIVE+1];
   logic [RUN_W-1:0]  min_run;
   logic [NOTE_W-1:0] held_note;
   logic [RUN_W-1:0]  held_run;
   note_result_type   expected_notes [$];
   note_result_type   oldest;

   function automatic logic [63:0] scaled_pitch(input int unsigned j);
      return (C0_SCALED * 64'(STEP_RATIO[j % 12])) << (j / 12);
   endfunction

   function automatic logic [FREQ_W-1:0] clamp_q8(input logic [63:0] v);
      return (v > 64'(Q8_MAX)) ? Q8_MAX : v[FREQ_W-1:0];
   endfunction

   // Maps one frequency onto a note and advances the run state.
   function automatic note_result_type predict_note(input logic [FREQ_W-1:0] f);
      note_result_type r;
      int hit;
      r = '0;
      hit = -1;
      if (f >= centre_tab[0] && f <= centre_tab[ACTIVE-1]) begin
         for (int i = 0; i < ACTIVE; i++) begin
            if (hit < 0 && f > bound_tab[i] && f < bound_tab[i+1]) begin
               hit = i;
            end
         end
      end
      if (hit >= 0) begin
         if (NOTE_W'(hit) == held_note) begin
            if (held_run != RUN_MAX) begin
               held_run = held_run + RUN_W'(1);
            end
         end else begin
            r.note_changed = 1'b1;
            r.replaced_short = (held_run < min_run);
            held_note = NOTE_W'(hit);
            held_run = RUN_W'(1);
         end
         r.accepted = 1'b1;
         r.note_index = NOTE_W'(hit);
         r.octave = OCT_W'(hit / 12);
      end
      r.run_length = held_run;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      for (int i = 0; i < ACTIVE; i++) begin
         centre_tab[i] = clamp_q8((scaled_pitch(i + 12) + PITCH_DEN / 2) / PITCH_DEN);
      end
      for (int i = 0; i <= ACTIVE; i++) begin
         bound_tab[i] = clamp_q8((scaled_pitch(i + 11) + scaled_pitch(i + 12) + PITCH_DEN)
                                 / (2 * PITCH_DEN));
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         min_run = MIN_SEG_RESET;
         held_note = NONE_NOTE;
         held_run = '0;
         expected_notes.delete();
      end else begin
         if (csr_wr_en) begin
            min_run = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            expected_notes.push_back(predict_note(req_frequency));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_notes.size() == 0) begin
               $error("Result item arrived with no request item waiting.");
               fail_count++;
            end else begin
               oldest = expected_notes.pop_front();
               check_field("accepted", 32'(oldest.accepted), 32'(rsp_accepted));
               check_field("note_index", 32'(oldest.note_index), 32'(rsp_note_index));
               check_field("octave", 32'(oldest.octave), 32'(rsp_octave));
               check_field("note_changed", 32'(oldest.note_changed),
                           32'(rsp_note_changed));
               check_field("replaced_short", 32'(oldest.replaced_short),
                           32'(rsp_replaced_short));
               check_field("run_length", 32'(oldest.run_length), 32'(rsp_run_length));
            end
         end
      end
      pending = expected_notes.size();
   end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Semitone note tracker testbench
// Drives frequency items into the tracker under changing sender and receiver
// idling, rewrites the minimum run length between phases and leaves the
// checking to the note checker. Directed items cover the range edges, exact
// boundaries and run replacement; random items are mostly runs of one note.
// A run longer than the minimum checks that ending it is not flagged short.
// ----------------------------------------------------------------------------
module tb_top;
   import snt_pkg::*;

   localparam int OCTAVES     = 9;
   localparam int NOTES       = 108;
   localparam int NOTE_COUNT  = (NOTES < OCTAVES * 12) ? NOTES : OCTAVES * 12;
   localparam int SETTLE      = 16;
   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_RUN    = 24;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [FREQ_W-1:0] req_frequency;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_accepted;
   logic [NOTE_W-1:0] rsp_note_index;
   logic [OCT_W-1:0]  rsp_octave;
   logic              rsp_note_changed;
   logic              rsp_replaced_short;
   logic [RUN_W-1:0]  rsp_run_length;
   logic              csr_wr_en;
   logic [RUN_W-1:0]  csr_wr_data;
   int                fail_count;
   int                pending;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                quiet_cycles = 0;

   semitone_note_tracker_core #(
      .OCTAVES (OCTAVES),
      .NOTES   (NOTES)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frequency      (req_frequency),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_note_index     (rsp_note_index),
      .rsp_octave         (rsp_octave),
      .rsp_note_changed   (rsp_note_changed),
      .rsp_replaced_short (rsp_replaced_short),
      .rsp_run_length     (rsp_run_length),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   tb_note_checker #(
      .OCTAVES (OCTAVES),
      .NOTES   (NOTES)
   ) i_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_frequency      (req_frequency),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_accepted       (rsp_accepted),
      .rsp_note_index     (rsp_note_index),
      .rsp_octave         (rsp_octave),
      .rsp_note_changed   (rsp_note_changed),
      .rsp_replaced_short (rsp_replaced_short),
      .rsp_run_length     (rsp_run_length),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [FREQ_W-1:0] freq_in_note(input int n);
      int unsigned lo;
      int unsigned hi;
      lo = 32'(i_check.bound_tab[n]) + 1;
      hi = 32'(i_check.bound_tab[n+1]) - 1;
      if (lo < 32'(i_check.centre_tab[0])) begin
         lo = 32'(i_check.centre_tab[0]);
      end
      if (hi > 32'(i_check.centre_tab[NOTE_COUNT-1])) begin
         hi = 32'(i_check.centre_tab[NOTE_COUNT-1]);
      end
      return FREQ_W'($urandom_range(hi, lo));
   endfunction

   task automatic send_freq(input logic [FREQ_W-1:0] f);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_frequency <= f;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending != 0);
   endtask

   task automatic set_min_run(input logic [RUN_W-1:0] v);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly runs of one note with random content, with noise between them.
   task automatic random_phase(input int n_items);
      int sent;
      int pick;
      int note;
      int run_len;
      sent = 0;
      note = $urandom_range(NOTE_COUNT - 1);
      while (sent < n_items) begin
         pick = $urandom_range(99);
         if (pick < 80) begin
            if ($urandom_range(2) == 0) begin
               note = (note == 0) ? 1 : (note == NOTE_COUNT - 1) ? note - 1
                    : note + ($urandom_range(1) ? 1 : -1);
            end else begin
               note = $urandom_range(NOTE_COUNT - 1);
            end
            run_len = $urandom_range(1, ($urandom_range(4) == 0) ? 8 : 4);
            for (int k = 0; k < run_len; k++) begin
               send_freq(freq_in_note(note));
               sent++;
            end
         end else begin
            if (pick < 88) begin
               send_freq(FREQ_W'($urandom()));
            end else if (pick < 94) begin
               send_freq(i_check.bound_tab[$urandom_range(NOTE_COUNT - 1, 1)]);
            end else if (pick < 97) begin
               send_freq(FREQ_W'($urandom_range(32'(i_check.centre_tab[0]) - 1)));
            end else begin
               send_freq(FREQ_W'($urandom_range(32'(Q8_MAX),
                                 32'(i_check.centre_tab[NOTE_COUNT-1]) + 1)));
            end
            sent++;
         end
         if ($urandom_range(59) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      int note;
      reset = 1'b1;
      req_valid = 1'b0;
      req_frequency = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      send_idle_pct = 37;
      recv_idle_pct = 62;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_freq('0);
      send_freq(Q8_MAX);
      send_freq(i_check.centre_tab[0] - 1'b1);
      send_freq(i_check.centre_tab[0]);
      send_freq(i_check.centre_tab[0]);
      send_freq(i_check.bound_tab[1]);
      send_freq(i_check.bound_tab[1] + 1'b1);
      send_freq(i_check.centre_tab[1]);
      send_freq(i_check.centre_tab[12]);
      send_freq(i_check.bound_tab[13] - 1'b1);
      send_freq(i_check.centre_tab[13]);
      send_freq(i_check.centre_tab[50]);
      send_freq(i_check.centre_tab[NOTE_COUNT-1]);
      send_freq(i_check.centre_tab[NOTE_COUNT-1] + 1'b1);
      send_freq(i_check.bound_tab[NOTE_COUNT-1]);
      send_freq(i_check.bound_tab[NOTE_COUNT-1] + 1'b1);
      send_freq(i_check.centre_tab[NOTE_COUNT-2]);
      send_freq(22'h2AAAAA);
      send_freq(22'h155555);
      send_freq(22'h200000);
      send_freq(i_check.bound_tab[0]);
      send_freq(i_check.centre_tab[60]);

      set_min_run('0);
      random_phase(220);

      send_idle_pct = 62;
      recv_idle_pct = 37;
      set_min_run(16'd3);
      random_phase(220);

      // A run longer than the minimum ends without a replacement flag, and
      // the one-item run after it ends with one.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_min_run(16'd20);
      note = $urandom_range(NOTE_COUNT - 2);
      for (int k = 0; k < LONG_RUN; k++) begin
         send_freq(freq_in_note(note));
      end
      send_freq(freq_in_note(note + 1));
      send_freq(freq_in_note(note));

      set_min_run(16'($urandom_range(5, 1)));
      random_phase(210);

      drain();
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
